// ===== sv/lzss_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the LZSS stream decoder: window geometry, field widths,
// parse phase codes and configuration register indexes. No dependencies.
package lzss_pkg;

    localparam int WINDOW_SIZE     = 4096;
    localparam int WIN_AW          = $clog2(WINDOW_SIZE);
    localparam int DEF_COUNT_WIDTH = 24;
    localparam int BYTE_W          = 8;
    localparam int LIMIT_W         = 24;
    localparam int MASK_W          = 8;
    localparam int CFG_IDX_W       = 1;
    localparam int RUN_W           = 5;   // holds a match length of up to 18

    localparam logic [WIN_AW-1:0] PTR_START = 12'hFEE;
    localparam logic [RUN_W-1:0]  LEN_BIAS  = 5'd3;
    localparam logic [3:0]        FIDX_NONE = 4'd8;

    // parse phase
    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_LIT  = 2'd1;
    localparam logic [1:0] PH_OFS  = 2'd2;
    localparam logic [1:0] PH_LEN  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DESCRAMBLE_MASK = 1'd1;

endpackage

// ===== sv/lzss_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// A read of the entry written in the same cycle returns the old contents.
module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/lzss_stream_decoder.sv =====
`timescale 1ns / 1ps
// LZSS stream decoder top level: parser, match copy engine and output register.
// Depends on lzss_pkg and lzss_ram (the 4096-byte history window).

// Takes one compressed byte per input transaction and gives decompressed bytes
// one per output transaction. A flag or offset byte only updates the parser; a
// literal or a length byte holds the input off until its bytes are emitted. A
// match of n bytes (3..18) is read through the window RAM's single read port,
// one byte per cycle while the output side keeps taking. The window needs no clearing pass:
// entries not yet written in the current stream are recognised from the
// emitted byte count and read as zero, so a stream start costs nothing.
// Configuration writes are taken at any time but are meant for idle periods.
module lzss_stream_decoder #(
    parameter int COUNT_WIDTH = lzss_pkg::DEF_COUNT_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // compressed input
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [lzss_pkg::BYTE_W-1:0]     i_s_tdata,   // [7:0] in_byte
    input  logic                            i_s_tuser,   // [0] stream_start
    input  logic                            i_s_tlast,   // in_last
    // decompressed output
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [31:0]                     o_m_tdata,   // [7:0] out_byte, [31:8] byte_count
    output logic                            o_m_tuser,   // [0] limit_reached
    output logic                            o_m_tlast,   // run_end
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lzss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lzss_pkg::LIMIT_W-1:0]    i_cfg_data
);

    import lzss_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LIT  = 2'd1;
    localparam logic [1:0] S_COPY = 2'd2;

    // configuration
    logic [LIMIT_W-1:0] r_limit;
    logic [MASK_W-1:0]  r_mask;

    // parser state
    logic [1:0]             r_state,    n_state;
    logic                   r_stopped,  n_stopped;
    logic [1:0]             r_phase,    n_phase;
    logic [3:0]             r_fidx,     n_fidx;
    logic [BYTE_W-1:0]      r_fbits,    n_fbits;
    logic [BYTE_W-1:0]      r_offlo,    n_offlo;
    logic [COUNT_WIDTH-1:0] r_count,    n_count;
    logic [BYTE_W-1:0]      r_pos,      n_pos;
    logic [WIN_AW-1:0]      r_wp,       n_wp;
    logic                   r_in_last,  n_in_last;
    logic [BYTE_W-1:0]      r_lit,      n_lit;

    // copy engine
    logic [WIN_AW-1:0]      r_rd_addr,  n_rd_addr;
    logic [RUN_W-1:0]       r_left,     n_left;
    logic [RUN_W-1:0]       r_iss_left, n_iss_left;
    logic                   r_pend,     n_pend;
    logic                   r_fwd,      n_fwd;
    logic [BYTE_W-1:0]      r_fwd_data, n_fwd_data;
    logic                   r_rd_valid, n_rd_valid;

    // output register
    logic                   r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]      r_out_byte,  n_out_byte;
    logic [LIMIT_W-1:0]     r_out_count, n_out_count;
    logic                   r_out_lim,   n_out_lim;
    logic                   r_out_last,  n_out_last;

    // window RAM
    logic [BYTE_W-1:0]      ram_q;
    logic                   iss;

    // helpers
    logic                   in_acc, st;
    logic                   e_stopped;
    logic [1:0]             e_phase;
    logic [COUNT_WIDTH-1:0] e_count;
    logic [BYTE_W-1:0]      e_pos;
    logic [WIN_AW-1:0]      e_wp;
    logic [3:0]             e_fidx;
    logic [BYTE_W-1:0]      din;
    logic [CMP_W-1:0]       limit_ext;
    logic                   e_emit_ok;
    logic                   can_load, emit_go, last, hit_lim, hit_max;
    logic [BYTE_W-1:0]      emit_data, copy_data;
    logic [COUNT_WIDTH-1:0] cnt_new;
    logic [CMP_W-1:0]       cnt_new_ext;
    logic [3:0]             nf_idx;
    logic [1:0]             nf_phase;
    logic [WIN_AW-1:0]      fill_dist;
    logic                   fill_ok;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign st          = in_acc && i_s_tuser;

    // state as seen by the incoming byte: a stream start restores it first
    assign e_stopped = st ? 1'b0 : r_stopped;
    assign e_phase   = st ? PH_FLAG : r_phase;
    assign e_count   = st ? '0 : r_count;
    assign e_pos     = st ? '0 : r_pos;
    assign e_wp      = st ? PTR_START : r_wp;
    assign e_fidx    = st ? FIDX_NONE : r_fidx;

    assign din       = i_s_tdata ^ (e_pos & r_mask);
    assign limit_ext = CMP_W'(r_limit);
    assign e_emit_ok = (CMP_W'(e_count) < limit_ext) && (e_count != COUNT_MAX);

    assign can_load  = !r_out_valid || i_m_tready;
    assign copy_data = r_fwd ? r_fwd_data : (r_rd_valid ? ram_q : '0);
    assign emit_go   = can_load && ((r_state == S_LIT) || ((r_state == S_COPY) && r_pend));
    assign emit_data = (r_state == S_LIT) ? r_lit : copy_data;

    assign cnt_new     = r_count + 1'b1;
    assign cnt_new_ext = CMP_W'(cnt_new);
    assign hit_lim     = (cnt_new_ext == limit_ext);
    assign hit_max     = (cnt_new == COUNT_MAX);
    assign last        = (r_state == S_LIT) || (r_left == RUN_W'(1)) || hit_lim || hit_max;

    assign nf_idx   = r_fidx + 4'd1;
    assign nf_phase = nf_idx[3] ? PH_FLAG : (r_fbits[nf_idx[2:0]] ? PH_LIT : PH_OFS);

    // an entry is written this stream if within count bytes of the start or count >= window size
    assign fill_dist = r_rd_addr - PTR_START;
    assign fill_ok   = (r_count >= COUNT_WIDTH'(WINDOW_SIZE))
                     || (COUNT_WIDTH'(fill_dist) < r_count);

    assign iss = (r_state == S_COPY) && (r_iss_left != '0) && (!r_pend || emit_go);

    lzss_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .i_clk     (i_clk),
        .i_wr_en   (emit_go),
        .i_wr_addr (r_wp),
        .i_wr_data (emit_data),
        .i_rd_en   (iss),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (ram_q)
    );

    always_comb begin
        n_state     = r_state;
        n_stopped   = r_stopped;
        n_phase     = r_phase;
        n_fidx      = r_fidx;
        n_fbits     = r_fbits;
        n_offlo     = r_offlo;
        n_count     = r_count;
        n_pos       = r_pos;
        n_wp        = r_wp;
        n_in_last   = r_in_last;
        n_lit       = r_lit;
        n_rd_addr   = r_rd_addr;
        n_left      = r_left;
        n_iss_left  = r_iss_left;
        n_pend      = r_pend;
        n_fwd       = r_fwd;
        n_fwd_data  = r_fwd_data;
        n_rd_valid  = r_rd_valid;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_count = r_out_count;
        n_out_lim   = r_out_lim;
        n_out_last  = r_out_last;

        if (in_acc) begin
            n_stopped = e_stopped;
            n_phase   = e_phase;
            n_count   = e_count;
            n_pos     = e_pos;
            n_wp      = e_wp;
            n_fidx    = e_fidx;
            if (!e_stopped) begin
                n_pos     = e_pos + 1'b1;
                n_in_last = i_s_tlast;
                unique case (e_phase)
                    PH_FLAG: begin
                        n_fbits = din;
                        n_fidx  = 4'd0;
                        n_phase = din[0] ? PH_LIT : PH_OFS;
                        if (i_s_tlast) n_stopped = 1'b1;
                    end
                    PH_LIT: begin
                        if (!e_emit_ok) begin
                            n_stopped = 1'b1;
                        end else begin
                            n_lit   = din;
                            n_state = S_LIT;
                        end
                    end
                    PH_OFS: begin
                        n_offlo = din;
                        n_phase = PH_LEN;
                        if (i_s_tlast) n_stopped = 1'b1;
                    end
                    PH_LEN: begin
                        if (!e_emit_ok) begin
                            n_stopped = 1'b1;
                        end else begin
                            n_rd_addr  = {din[7:4], r_offlo};
                            n_left     = RUN_W'(din[3:0]) + LEN_BIAS;
                            n_iss_left = RUN_W'(din[3:0]) + LEN_BIAS;
                            n_pend     = 1'b0;
                            n_state    = S_COPY;
                        end
                    end
                    default: n_stopped = 1'b1;
                endcase
            end
        end

        // window read, with forwarding of the byte written in the same cycle
        if (iss) begin
            n_rd_addr  = r_rd_addr + 1'b1;
            n_iss_left = r_iss_left - 1'b1;
            n_fwd      = emit_go && (r_rd_addr == r_wp);
            n_fwd_data = emit_data;
            n_rd_valid = fill_ok;
            n_pend     = 1'b1;
        end else if (emit_go) begin
            n_pend = 1'b0;
        end

        if (emit_go) begin
            n_out_valid = 1'b1;
            n_out_byte  = emit_data;
            n_out_count = cnt_new_ext[LIMIT_W-1:0];
            n_out_lim   = hit_lim;
            n_out_last  = last;
            n_wp        = r_wp + 1'b1;
            n_count     = cnt_new;
            n_left      = r_left - 1'b1;
            if (last) begin
                n_state = S_IDLE;
                n_pend  = 1'b0;
                if (hit_lim) begin
                    n_stopped = 1'b1;
                end else if ((r_state == S_LIT) || (r_left == RUN_W'(1))) begin
                    n_fidx  = nf_idx[3] ? FIDX_NONE : nf_idx;
                    n_phase = nf_phase;
                end else begin
                    // counter saturated mid-match
                    n_stopped = 1'b1;
                end
                if (r_in_last) n_stopped = 1'b1;
            end
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stopped   <= 1'b0;
            r_phase     <= PH_FLAG;
            r_fidx      <= FIDX_NONE;
            r_count     <= '0;
            r_pos       <= '0;
            r_wp        <= PTR_START;
            r_in_last   <= 1'b0;
            r_left      <= '0;
            r_iss_left  <= '0;
            r_pend      <= 1'b0;
            r_fwd       <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_limit     <= '0;
            r_mask      <= '0;
        end else begin
            r_state     <= n_state;
            r_stopped   <= n_stopped;
            r_phase     <= n_phase;
            r_fidx      <= n_fidx;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_wp        <= n_wp;
            r_in_last   <= n_in_last;
            r_left      <= n_left;
            r_iss_left  <= n_iss_left;
            r_pend      <= n_pend;
            r_fwd       <= n_fwd;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_OUTPUT_LIMIT:    r_limit <= i_cfg_data;
                    REG_DESCRAMBLE_MASK: r_mask  <= i_cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fbits     <= n_fbits;
        r_offlo     <= n_offlo;
        r_lit       <= n_lit;
        r_rd_addr   <= n_rd_addr;
        r_fwd_data  <= n_fwd_data;
        r_out_byte  <= n_out_byte;
        r_out_count <= n_out_count;
        r_out_lim   <= n_out_lim;
        r_out_last  <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_count, r_out_byte};
    assign o_m_tuser  = r_out_lim;
    assign o_m_tlast  = r_out_last;

`ifndef SYNTHESIS
    // reaching the limit always closes the run of results for that byte
    a_lim_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("limit_reached without run_end");

    // during a copy, bytes still to emit = reads still to issue + read in flight
    a_copy_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_left == r_iss_left + RUN_W'(r_pend)))
        else $error("copy engine read/emit count mismatch");

    // literal and length phases need a flag bit in hand
    a_flag_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LIT || r_phase == PH_LEN) |-> (r_fidx < FIDX_NONE))
        else $error("data phase without a current flag bit");

    // a fresh result is only loaded while the previous one is taken or absent
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> ($past(o_m_tlast) == o_m_tlast))
        else $error("output register overwritten while stalled");
`endif

endmodule
